>>> sv/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared types and constants of the radix-2 fft block
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int BIN_BITS     = 22;
    localparam int BIN_NUM_BITS = 6;
    localparam int SIZE_BITS    = 3;
    localparam logic [SIZE_BITS-1:0] SIZE_LOG2_RESET = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_ADD,
        ST_BF_WE,
        ST_BF_WO,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    typedef struct packed {
        logic store_we;
        logic copy_rd;
        logic copy_wr;
        logic bf_rd;
        logic bf_mul;
        logic bf_add;
        logic bf_we_even;
        logic bf_we_odd;
        logic em_rd;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> sv/r2fft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ctrl
// sequencer: frame loading, bit-reversed copy, butterfly passes, bin emission
// ----------------------------------------------------------------------------
module r2fft_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           size_log2_we,
    input  logic [r2fft_pkg::SIZE_BITS-1:0] size_log2_wdata,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  r2fft_pkg::status_t             status,
    output r2fft_pkg::cmd_t                cmd,
    output logic [$clog2(MAX_POINTS)-1:0]  store_waddr,
    output logic [$clog2(MAX_POINTS)-1:0]  idx,
    output logic [$clog2(MAX_POINTS)-1:0]  rev_addr,
    output logic [$clog2(MAX_POINTS)-1:0]  even_addr,
    output logic [$clog2(MAX_POINTS)-1:0]  odd_addr,
    output logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS)-1 : 1)-1:0] tw_idx
);
    import r2fft_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int LCW = AW + 1;
    localparam int LGW = $clog2(AW + 1);
    localparam int TIW = (AW > 1) ? AW - 1 : 1;

    state_t               state_reg, state_next;
    logic [SIZE_BITS-1:0] size_reg;
    logic [LCW-1:0]       lc_reg, lc_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        bf_reg, bf_next;
    logic [LGW-1:0]       stage_reg, stage_next;

    logic [LGW-1:0] lg;
    logic [LCW-1:0] n_val;
    logic [LCW-1:0] lc_inc;
    logic [AW-1:0]  k_val;
    logic [AW-1:0]  half_bit;
    logic           idx_last;
    logic           bf_last;
    logic           stage_last;

    // clamp the programmed length to 1..log2 of the built size
    always_comb
    begin
        if (size_reg == '0)
            lg = LGW'(1);
        else if (int'(size_reg) > AW)
            lg = LGW'(AW);
        else
            lg = LGW'(size_reg);
    end

    assign n_val      = LCW'(1) << lg;
    assign lc_inc     = lc_reg + LCW'(1);
    assign idx_last   = ({1'b0, idx_reg} == n_val - LCW'(1));
    assign bf_last    = ({1'b0, bf_reg} == (n_val >> 1) - LCW'(1));
    assign stage_last = (stage_reg == lg - LGW'(1));

    assign half_bit  = AW'(1) << stage_reg;
    assign k_val     = bf_reg & (half_bit - AW'(1));
    assign even_addr = ((bf_reg >> stage_reg) << (stage_reg + LGW'(1))) | k_val;
    assign odd_addr  = even_addr | half_bit;
    assign tw_idx    = TIW'(k_val << (AW - 1 - int'(stage_reg)));

    always_comb
    begin
        rev_addr = '0;
        for (int b = 0; b < AW; b++)
        begin
            if (b < int'(lg))
                rev_addr[int'(lg) - 1 - b] = idx_reg[b];
        end
    end

    assign store_waddr = lc_reg[AW-1:0];
    assign idx         = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_LOG2_RESET;
            lc_reg    <= '0;
            idx_reg   <= '0;
            bf_reg    <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            idx_reg   <= idx_next;
            bf_reg    <= bf_next;
            stage_reg <= stage_next;
            if (size_log2_we)
                size_reg <= size_log2_wdata;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        lc_next      = lc_reg;
        idx_next     = idx_reg;
        bf_next      = bf_reg;
        stage_next   = stage_reg;
        cmd          = '0;
        sample_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.store_we = 1'b1;
                    if (lc_inc >= n_val)
                    begin
                        lc_next    = '0;
                        idx_next   = '0;
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        lc_next = lc_inc;
                    end
                end
            end
            ST_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (idx_last)
                begin
                    bf_next    = '0;
                    stage_next = '0;
                    state_next = ST_BF_RD;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_BF_RD:
            begin
                cmd.bf_rd  = 1'b1;
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                cmd.bf_mul = 1'b1;
                state_next = ST_BF_ADD;
            end
            ST_BF_ADD:
            begin
                cmd.bf_add = 1'b1;
                state_next = ST_BF_WE;
            end
            ST_BF_WE:
            begin
                cmd.bf_we_even = 1'b1;
                state_next     = ST_BF_WO;
            end
            ST_BF_WO:
            begin
                cmd.bf_we_odd = 1'b1;
                state_next    = ST_BF_RD;
                if (bf_last)
                begin
                    bf_next = '0;
                    if (stage_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_EM_RD;
                    end
                    else
                    begin
                        stage_next = stage_reg + LGW'(1);
                    end
                end
                else
                begin
                    bf_next = bf_reg + AW'(1);
                end
            end
            ST_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = idx_last;
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/r2fft_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_dp
// sample store, work memory, twiddle rom, butterfly unit and output register
// ----------------------------------------------------------------------------
module r2fft_dp #(
    parameter int MAX_POINTS   = 64,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  r2fft_pkg::cmd_t                      cmd,
    output r2fft_pkg::status_t                   status,
    input  logic [$clog2(MAX_POINTS)-1:0]        store_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]        idx,
    input  logic [$clog2(MAX_POINTS)-1:0]        rev_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]        even_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]        odd_addr,
    input  logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS)-1 : 1)-1:0] tw_idx,
    input  logic signed [SAMPLE_BITS-1:0]        sample_real,
    input  logic signed [SAMPLE_BITS-1:0]        sample_imag,
    output logic signed [r2fft_pkg::BIN_BITS-1:0] bin_real,
    output logic signed [r2fft_pkg::BIN_BITS-1:0] bin_imag,
    output logic [r2fft_pkg::BIN_NUM_BITS-1:0]   bin_number,
    output logic                                 final_bin,
    output logic                                 bin_valid,
    input  logic                                 bin_stall
);
    import r2fft_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int HALF = MAX_POINTS / 2;
    localparam int TB   = TWIDDLE_BITS;
    localparam int WW   = SAMPLE_BITS + AW + 2;
    localparam int PW   = WW + TB;
    localparam int EW   = (WW > BIN_BITS) ? WW : BIN_BITS;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // twiddles from a q2.30 taylor series, then rounded to q1.(TB-1)
    function automatic longint unsigned quant_tw(input longint signed v);
        longint unsigned sh;
        longint unsigned mx;
        longint unsigned r;
        sh = 64'(30 - (TB - 1));
        mx = (64'd1 << (TB - 1)) - 64'd1;
        if (v < 0)
            r = 0;
        else
            r = (longint'(unsigned'(v)) + (64'd1 << (sh - 1))) >> sh;
        return (r > mx) ? mx : r;
    endfunction

    function automatic logic [HALF*2*TB-1:0] build_tw();
        logic [HALF*2*TB-1:0] rom;
        longint unsigned x, x2, t, ix;
        longint signed   acc_s, acc_c;
        longint unsigned qs, qc;
        logic            upper;
        rom = '0;
        for (int k = 0; k < HALF; k++)
        begin
            upper = (4 * k > MAX_POINTS);
            ix    = upper ? 64'(HALF - k) : 64'(k);
            x     = (64'd2 * PI_Q30 * ix) / MAX_POINTS;
            x2    = (x * x) >> 30;
            t     = x;
            acc_s = longint'(x);
            for (int j = 1; j <= 12; j++)
            begin
                t = ((t * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
                acc_s = (j % 2 == 1) ? acc_s - longint'(t) : acc_s + longint'(t);
            end
            t     = ONE_Q30;
            acc_c = longint'(ONE_Q30);
            for (int j = 1; j <= 12; j++)
            begin
                t = ((t * x2) >> 30) / 64'((2 * j - 1) * (2 * j));
                acc_c = (j % 2 == 1) ? acc_c - longint'(t) : acc_c + longint'(t);
            end
            qs = quant_tw(acc_s);
            qc = quant_tw(acc_c);
            rom[k*2*TB +: TB]    = upper ? TB'(-qc) : TB'(qc);
            rom[k*2*TB+TB +: TB] = TB'(-qs);
        end
        return rom;
    endfunction

    localparam logic [HALF*2*TB-1:0] TW_ROM = build_tw();

    logic [2*SAMPLE_BITS-1:0] store_mem [MAX_POINTS];
    logic [2*WW-1:0]          work_mem  [MAX_POINTS];

    logic [2*SAMPLE_BITS-1:0] store_rd_reg;
    logic [2*WW-1:0]          rd_a_reg;
    logic [2*WW-1:0]          rd_b_reg;

    logic signed [PW-1:0] pr_rr_reg, pr_ii_reg, pr_ri_reg, pr_ir_reg;
    logic signed [WW-1:0] e_re_reg, e_im_reg;
    logic signed [WW-1:0] sum_e_re_reg, sum_e_im_reg, sum_o_re_reg, sum_o_im_reg;

    logic signed [BIN_BITS-1:0]  bin_real_reg, bin_imag_reg;
    logic [BIN_NUM_BITS-1:0]     bin_number_reg;
    logic                        final_bin_reg;
    logic                        bin_valid_reg;

    logic [AW-1:0]        work_waddr;
    logic [2*WW-1:0]      work_wdata;
    logic                 work_we;
    logic [AW-1:0]        rd_a_addr;
    logic signed [WW-1:0] o_re, o_im;
    logic signed [TB-1:0] cr, ci;
    logic signed [PW:0]   acc_r, acc_i;
    logic signed [WW+1:0] tr, ti;
    logic signed [WW-1:0] copy_re, copy_im;

    // ---- memories
    assign copy_re = WW'(signed'(store_rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]));
    assign copy_im = WW'(signed'(store_rd_reg[SAMPLE_BITS-1:0]));

    assign work_we = cmd.copy_wr | cmd.bf_we_even | cmd.bf_we_odd;
    always_comb
    begin
        if (cmd.copy_wr)
        begin
            work_waddr = rev_addr;
            work_wdata = {copy_re, copy_im};
        end
        else if (cmd.bf_we_even)
        begin
            work_waddr = even_addr;
            work_wdata = {sum_e_re_reg, sum_e_im_reg};
        end
        else
        begin
            work_waddr = odd_addr;
            work_wdata = {sum_o_re_reg, sum_o_im_reg};
        end
    end
    assign rd_a_addr = cmd.bf_rd ? even_addr : idx;

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
            store_mem[store_waddr] <= {sample_real, sample_imag};
        if (cmd.copy_rd)
            store_rd_reg <= store_mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_waddr] <= work_wdata;
        if (cmd.bf_rd || cmd.em_rd)
            rd_a_reg <= work_mem[rd_a_addr];
        if (cmd.bf_rd)
            rd_b_reg <= work_mem[odd_addr];
    end

    // ---- butterfly
    assign o_re = signed'(rd_b_reg[2*WW-1:WW]);
    assign o_im = signed'(rd_b_reg[WW-1:0]);
    assign cr   = signed'(TW_ROM[int'(tw_idx)*2*TB +: TB]);
    assign ci   = signed'(TW_ROM[int'(tw_idx)*2*TB+TB +: TB]);

    // round half up, then floor shift back to sample units
    assign acc_r = (PW+1)'(pr_rr_reg) - (PW+1)'(pr_ii_reg) + (PW+1)'(1 << (TB - 2));
    assign acc_i = (PW+1)'(pr_ri_reg) + (PW+1)'(pr_ir_reg) + (PW+1)'(1 << (TB - 2));
    assign tr    = signed'(acc_r[PW:TB-1]);
    assign ti    = signed'(acc_i[PW:TB-1]);

    always_ff @(posedge clk)
    begin
        if (cmd.bf_mul)
        begin
            pr_rr_reg <= PW'(o_re) * PW'(cr);
            pr_ii_reg <= PW'(o_im) * PW'(ci);
            pr_ri_reg <= PW'(o_re) * PW'(ci);
            pr_ir_reg <= PW'(o_im) * PW'(cr);
            e_re_reg  <= signed'(rd_a_reg[2*WW-1:WW]);
            e_im_reg  <= signed'(rd_a_reg[WW-1:0]);
        end
        if (cmd.bf_add)
        begin
            sum_e_re_reg <= WW'((WW+2)'(e_re_reg) + tr);
            sum_e_im_reg <= WW'((WW+2)'(e_im_reg) + ti);
            sum_o_re_reg <= WW'((WW+2)'(e_re_reg) - tr);
            sum_o_im_reg <= WW'((WW+2)'(e_im_reg) - ti);
        end
    end

    // ---- output word
    function automatic logic signed [BIN_BITS-1:0] sat_bin(input logic signed [WW-1:0] v);
        logic signed [EW-1:0] ve;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        ve = EW'(v);
        hi = EW'((64'sd1 <<< (BIN_BITS - 1)) - 64'sd1);
        lo = -hi - EW'(1);
        if (ve > hi)
            return BIN_BITS'(hi);
        else if (ve < lo)
            return BIN_BITS'(lo);
        else
            return BIN_BITS'(ve);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            bin_real_reg   <= sat_bin(signed'(rd_a_reg[2*WW-1:WW]));
            bin_imag_reg   <= sat_bin(signed'(rd_a_reg[WW-1:0]));
            bin_number_reg <= BIN_NUM_BITS'(idx);
            final_bin_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_valid_reg <= 1'b0;
        else if (cmd.out_load)
            bin_valid_reg <= 1'b1;
        else if (!bin_stall)
            bin_valid_reg <= 1'b0;
    end

    assign status.out_free = !bin_valid_reg || !bin_stall;
    assign bin_real   = bin_real_reg;
    assign bin_imag   = bin_imag_reg;
    assign bin_number = bin_number_reg;
    assign final_bin  = final_bin_reg;
    assign bin_valid  = bin_valid_reg;

endmodule

>>> sv/radix2_complex_fft.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_complex_fft
// radix-2 decimation-in-time forward fft, one shared butterfly unit
//
//   channel   direction  handshake                      word
//   sample    in         sample_valid / sample_stall    sample_real, sample_imag
//   bin       out        bin_valid / bin_stall          bin_real, bin_imag,
//                                                       bin_number, final_bin
//   config    in         size_log2_we                   size_log2_wdata
//
// samples are accepted back to back while idle; the last sample of a frame of n
// starts the transform: a bit-reversed copy, then n/2*log2(n) butterflies, each
// read, multiplied, added and written back even then odd by the single butterfly
// unit and its one-write work memory, then emission of the bins.
// reset clears the sequencer and sets size_log2 to 6; memories are not cleared.
// bin_stall holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module radix2_complex_fft #(
    parameter int MAX_POINTS   = 64,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  size_log2_we,
    input  logic [r2fft_pkg::SIZE_BITS-1:0]       size_log2_wdata,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample_real,
    input  logic signed [SAMPLE_BITS-1:0]         sample_imag,
    output logic                                  bin_valid,
    input  logic                                  bin_stall,
    output logic signed [r2fft_pkg::BIN_BITS-1:0] bin_real,
    output logic signed [r2fft_pkg::BIN_BITS-1:0] bin_imag,
    output logic [r2fft_pkg::BIN_NUM_BITS-1:0]    bin_number,
    output logic                                  final_bin
);
    import r2fft_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int TIW = (AW > 1) ? AW - 1 : 1;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] store_waddr;
    logic [AW-1:0] idx;
    logic [AW-1:0] rev_addr;
    logic [AW-1:0] even_addr;
    logic [AW-1:0] odd_addr;
    logic [TIW-1:0] tw_idx;

    r2fft_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .size_log2_we    (size_log2_we),
        .size_log2_wdata (size_log2_wdata),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .status          (status),
        .cmd             (cmd),
        .store_waddr     (store_waddr),
        .idx             (idx),
        .rev_addr        (rev_addr),
        .even_addr       (even_addr),
        .odd_addr        (odd_addr),
        .tw_idx          (tw_idx)
    );

    r2fft_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .store_waddr (store_waddr),
        .idx         (idx),
        .rev_addr    (rev_addr),
        .even_addr   (even_addr),
        .odd_addr    (odd_addr),
        .tw_idx      (tw_idx),
        .sample_real (sample_real),
        .sample_imag (sample_imag),
        .bin_real    (bin_real),
        .bin_imag    (bin_imag),
        .bin_number  (bin_number),
        .final_bin   (final_bin),
        .bin_valid   (bin_valid),
        .bin_stall   (bin_stall)
    );

`ifndef SYNTHESIS
    // nothing follows the last bin until a new frame has been loaded
    a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_stall && final_bin |=> !bin_valid)
        else $error("bin emitted right after final bin");

    // samples stay blocked while a frame is still being emitted
    a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !final_bin |-> sample_stall)
        else $error("sample taken in the middle of emission");

    // a bin with number zero is never flagged final, since n is at least two
    a_final_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && final_bin |-> bin_number != '0)
        else $error("final flag on bin zero");
`endif

endmodule
